[sv/vln_pkg.sv]
// ----------------------------------------------------------------------------
// vln_pkg
// Shared widths, register map, controller states and the command/status
// structs that join the controller and the datapath of the L2 normalizer.
// ----------------------------------------------------------------------------
package vln_pkg;

   // element and vector geometry
   localparam int ELEM_BITS  = 16;
   localparam int MAX_DIMS   = 64;
   localparam int DIMS_BITS  = $clog2(MAX_DIMS + 1);
   localparam int ADDR_BITS  = $clog2(MAX_DIMS);

   // Q1.15 result
   localparam int OUT_BITS   = 16;
   localparam int FRAC_BITS  = 15;

   // sum of squares (plus one unit) and its floor square root
   localparam int SUM_BITS   = 2 * (ELEM_BITS - 1) + DIMS_BITS;
   localparam int ROOT_BITS  = (SUM_BITS + 1) / 2;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

   // magnitude scaled by 2^FRAC_BITS before the divide
   localparam int NUM_BITS   = ELEM_BITS + FRAC_BITS;

   // divider retires two quotient bits per cycle
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS  = OUT_BITS / DIV_RADIX_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // register port
   localparam int PADDR_BITS = 3;
   localparam int PDATA_BITS = 32;
   localparam int CSR_IDX_BITS = PADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_IDX_DIMS = '0;
   localparam logic [DIMS_BITS-1:0] DIMS_RESET = DIMS_BITS'(MAX_DIMS);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_FETCH,
      ST_LOAD,
      ST_DIVIDE,
      ST_SEND
   } vln_state_type;

   typedef struct packed {
      logic accept;      // store element, add its square
      logic root_start;  // load sum + 1 into the square root unit
      logic root_step;   // one result bit of the square root
      logic div_load;    // load the fetched element into the divider
      logic div_step;    // two quotient bits
      logic out_next;    // result item taken, move to next element
   } vln_cmd_type;

   typedef struct packed {
      logic vec_done;    // the element now offered completes the vector
      logic root_done;   // square root is on its final step
      logic div_done;    // divider is on its final step
      logic last;        // current element is the final one of the vector
   } vln_status_type;

endpackage

[sv/vln_if.sv]
// ----------------------------------------------------------------------------
// vln_if
// Valid/ready stream channels of the L2 normalizer: element input and
// normalized result output.
// ----------------------------------------------------------------------------
interface vln_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vln_pkg::ELEM_BITS-1:0]  element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

interface vln_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vln_pkg::OUT_BITS-1:0]   normalized;
   logic                                  last;

   modport source (output valid, output normalized, output last, input ready);
   modport sink   (input valid, input normalized, input last, output ready);
endinterface

[sv/vln_ctrl.sv]
// ----------------------------------------------------------------------------
// vln_ctrl
// Sequencer: collects a vector, runs the square root, then fetches, divides
// and sends each stored element in turn.
// ----------------------------------------------------------------------------
module vln_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output vln_pkg::vln_cmd_type    cmd,
   input  vln_pkg::vln_status_type status
);

   vln_pkg::vln_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vln_pkg::ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         vln_pkg::ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.vec_done) begin
                  state_in = vln_pkg::ST_ROOT_INIT;
               end
            end
         end
         vln_pkg::ST_ROOT_INIT: begin
            cmd.root_start = 1'b1;
            state_in       = vln_pkg::ST_ROOT;
         end
         vln_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_done) begin
               state_in = vln_pkg::ST_FETCH;
            end
         end
         // memory read data lands at the end of this cycle
         vln_pkg::ST_FETCH: begin
            state_in = vln_pkg::ST_LOAD;
         end
         vln_pkg::ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = vln_pkg::ST_DIVIDE;
         end
         vln_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = vln_pkg::ST_SEND;
            end
         end
         vln_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.out_next = 1'b1;
               state_in = status.last ? vln_pkg::ST_COLLECT : vln_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = vln_pkg::ST_COLLECT;
         end
      endcase
   end

endmodule

[sv/vln_dp.sv]
// ----------------------------------------------------------------------------
// vln_dp
// Datapath: element store, sum of squares, bit-serial floor square root,
// radix-4 restoring divider and Q1.15 saturation.
// ----------------------------------------------------------------------------
module vln_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vln_pkg::vln_cmd_type                 cmd,
   output vln_pkg::vln_status_type              status,
   input  logic [vln_pkg::DIMS_BITS-1:0]        dims,
   input  logic signed [vln_pkg::ELEM_BITS-1:0] element,
   output logic signed [vln_pkg::OUT_BITS-1:0]  normalized,
   output logic                                 last
);

   localparam int EB = vln_pkg::ELEM_BITS;
   localparam int DB = vln_pkg::DIMS_BITS;
   localparam int AB = vln_pkg::ADDR_BITS;
   localparam int SB = vln_pkg::SUM_BITS;
   localparam int RB = vln_pkg::ROOT_BITS;
   localparam int OB = vln_pkg::OUT_BITS;
   localparam int NB = vln_pkg::NUM_BITS;
   localparam int RCB = vln_pkg::ROOT_CNT_BITS;
   localparam int DCB = vln_pkg::DIV_CNT_BITS;
   localparam logic [SB-1:0] ROOT_BIT_INIT = SB'(1) << (2 * (RB - 1));
   localparam logic [OB-1:0] POS_MAX = OB'((1 << vln_pkg::FRAC_BITS) - 1);
   localparam logic [OB-1:0] NEG_MAG = OB'(1 << vln_pkg::FRAC_BITS);

   // element store
   logic signed [EB-1:0] store_mem [vln_pkg::MAX_DIMS];
   logic signed [EB-1:0] rd_data_ff;

   logic [DB-1:0] count_ff;
   logic [AB-1:0] idx_ff;
   logic [SB-1:0] sum_ff;

   // square root unit
   logic [SB-1:0]  val_ff, val_in;
   logic [SB:0]    res_ff, res_in;
   logic [SB-1:0]  bit_ff;
   logic [RCB-1:0] root_cnt_ff;
   logic [RB-1:0]  norm_ff;
   logic [SB:0]    root_trial;

   // divider
   logic [RB-1:0]  rem_ff, rem_in;
   logic [OB-1:0]  tail_ff, tail_in;
   logic [OB-1:0]  quo_ff, quo_in;
   logic           neg_ff;
   logic [DCB-1:0] div_cnt_ff;
   logic [RB:0]    div_wide;

   logic [EB-1:0]   in_mag;
   logic [2*EB-1:0] in_square;
   logic [EB-1:0]   rd_mag;
   logic [NB-1:0]   rd_scaled;
   logic [DB-1:0]   eff_dims;
   logic [DB-1:0]   count_inc;

   // effective vector length: zero acts as one, oversize clamps
   always_comb begin
      priority if (dims == '0) begin
         eff_dims = DB'(1);
      end else if (dims > DB'(vln_pkg::MAX_DIMS)) begin
         eff_dims = DB'(vln_pkg::MAX_DIMS);
      end else begin
         eff_dims = dims;
      end
   end

   assign count_inc = count_ff + DB'(1);
   assign in_mag    = element[EB-1] ? EB'(-element) : EB'(element);
   assign in_square = in_mag * in_mag;
   assign rd_mag    = rd_data_ff[EB-1] ? EB'(-rd_data_ff) : EB'(rd_data_ff);
   assign rd_scaled = {rd_mag, {vln_pkg::FRAC_BITS{1'b0}}};

   assign status.vec_done  = (count_inc >= eff_dims);
   assign status.root_done = (root_cnt_ff == RCB'(RB - 1));
   assign status.div_done  = (div_cnt_ff == DCB'(vln_pkg::DIV_STEPS - 1));
   assign status.last      = ({1'b0, idx_ff} == DB'(count_ff - DB'(1)));
   assign last             = status.last;

   // store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[count_ff[AB-1:0]] <= element;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   // element count, read index and running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         if (cmd.accept) begin
            count_ff <= count_inc;
            sum_ff   <= sum_ff + SB'(in_square);
         end else if (cmd.root_start) begin
            sum_ff <= '0;
         end
         if (cmd.out_next) begin
            if (status.last) begin
               idx_ff   <= '0;
               count_ff <= '0;
            end else begin
               idx_ff <= idx_ff + AB'(1);
            end
         end
      end
   end

   // one square root step: try res + bit against the remaining value
   always_comb begin
      root_trial = res_ff + {1'b0, bit_ff};
      if ({1'b0, val_ff} >= root_trial) begin
         val_in = val_ff - root_trial[SB-1:0];
         res_in = (res_ff >> 1) + {1'b0, bit_ff};
      end else begin
         val_in = val_ff;
         res_in = res_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_cnt_ff <= '0;
         norm_ff     <= '0;
      end else begin
         if (cmd.root_start) begin
            root_cnt_ff <= '0;
         end else if (cmd.root_step) begin
            root_cnt_ff <= root_cnt_ff + RCB'(1);
            if (status.root_done) begin
               norm_ff <= (res_in == '0) ? RB'(1) : res_in[RB-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         val_ff <= sum_ff + SB'(1);
         res_ff <= '0;
         bit_ff <= ROOT_BIT_INIT;
      end else if (cmd.root_step) begin
         val_ff <= val_in;
         res_ff <= res_in;
         bit_ff <= bit_ff >> 2;
      end
   end

   // two restoring divide steps per cycle
   always_comb begin
      rem_in   = rem_ff;
      tail_in  = tail_ff;
      quo_in   = quo_ff;
      div_wide = '0;
      for (int i = 0; i < vln_pkg::DIV_RADIX_BITS; i++) begin
         div_wide = {rem_in, tail_in[OB-1]};
         tail_in  = tail_in << 1;
         if (div_wide >= {1'b0, norm_ff}) begin
            div_wide = div_wide - {1'b0, norm_ff};
            quo_in   = {quo_in[OB-2:0], 1'b1};
         end else begin
            quo_in   = {quo_in[OB-2:0], 1'b0};
         end
         rem_in = div_wide[RB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DCB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= RB'(rd_scaled[NB-1:OB]);
         tail_ff <= rd_scaled[OB-1:0];
         quo_ff  <= '0;
         neg_ff  <= rd_data_ff[EB-1];
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         tail_ff <= tail_in;
         quo_ff  <= quo_in;
      end
   end

   // sign and Q1.15 saturation
   always_comb begin
      if (neg_ff) begin
         normalized = (quo_ff > NEG_MAG) ? $signed(NEG_MAG) : $signed(OB'(-quo_ff));
      end else begin
         normalized = (quo_ff > POS_MAX) ? $signed(POS_MAX) : $signed(quo_ff);
      end
   end

endmodule

[sv/vector_l2_normalizer.sv]
// ----------------------------------------------------------------------------
// vector_l2_normalizer
// L2 normalization of a stream of signed vectors into Q1.15 results.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle until the vector holds dims of them
// (dims 0 acts as 1, above 64 as 64). After the final element the block
// takes the floor square root of the sum of squares plus one (one result
// bit per cycle), then sends each element as trunc(e * 32768 / N)
// saturated to 16 bits, with last set on the final one. Each result
// passes through a store read, a divider load, the two-bit-per-cycle
// divider and the send, which waits for the sink to be ready. No new
// element is taken until the last result of the vector is sent.
// dims is register 0 (byte address 0) of the register port.
module vector_l2_normalizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [vln_pkg::PADDR_BITS-1:0]     csr_paddr,
   input  logic [vln_pkg::PDATA_BITS-1:0]     csr_pwdata,
   output logic [vln_pkg::PDATA_BITS-1:0]     csr_prdata,
   output logic                               csr_pready,
   vln_req_if.sink                            req_ch,
   vln_rsp_if.source                          rsp_ch
);

   logic [vln_pkg::DIMS_BITS-1:0] dims_ff;
   logic                          dims_sel;
   vln_pkg::vln_cmd_type          cmd;
   vln_pkg::vln_status_type       status;

   assign csr_pready = 1'b1;
   assign dims_sel   = (csr_paddr[vln_pkg::PADDR_BITS-1:2] == vln_pkg::CSR_IDX_DIMS);

   // dims register
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= vln_pkg::DIMS_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && dims_sel) begin
         dims_ff <= csr_pwdata[vln_pkg::DIMS_BITS-1:0];
      end
   end

   assign csr_prdata = dims_sel ? vln_pkg::PDATA_BITS'(dims_ff) : '0;

   vln_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   vln_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .dims       (dims_ff),
      .element    (req_ch.element),
      .normalized (rsp_ch.normalized),
      .last       (rsp_ch.last)
   );

endmodule

[test/tb_vector_l2_normalizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_l2_normalizer
// Self-checking bench for the L2 normalizer. Elements go in over the request
// channel, and a scoreboard forms each vector, takes the floor root of the
// sum of squares plus one and predicts every Q1.15 result. Results are then
// checked in order. Directed cases cover the field extremes, saturation and
// dims changes. Random phases follow, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_vector_l2_normalizer;
   import vln_pkg::*;

   localparam int RANDOM_ITEMS = 135;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE       = 40;    // root pass plus a result or so
   localparam int HOLD_CYCLES  = 300;

   localparam logic [PADDR_BITS-1:0] DIMS_ADDR = PADDR_BITS'({CSR_IDX_DIMS, 2'b00});
   localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS;
   localparam logic signed [OUT_BITS-1:0]  OUT_MAX  = 16'sh7FFF;
   localparam logic signed [OUT_BITS-1:0]  OUT_MIN  = 16'sh8000;
   localparam logic signed [ELEM_BITS-1:0] ELEM_MAX = 16'sh7FFF;
   localparam logic signed [ELEM_BITS-1:0] ELEM_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] normalized;
      logic                       last;
   } norm_result_type;

   // predicts normalized vectors and checks results in order
   class norm_scoreboard;
      logic [DIMS_BITS-1:0]        dims_reg;
      logic signed [ELEM_BITS-1:0] vector_q[$];
      longint unsigned             square_sum;
      norm_result_type             expected_q[$];
      int                          errors;

      function new();
         dims_reg   = DIMS_RESET;
         square_sum = 0;
         errors     = 0;
      endfunction

      function void set_dims(logic [DIMS_BITS-1:0] d);
         dims_reg = d;
      endfunction

      function int effective_dims(logic [DIMS_BITS-1:0] d);
         if (d == 0) return 1;
         if (d > MAX_DIMS) return MAX_DIMS;
         return int'(d);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // floor square root, built one bit at a time from the top
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = 20; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // element accepted: store it; on the closing one queue the whole vector
      function void note_element(logic signed [ELEM_BITS-1:0] e);
         longint          ev;
         longint unsigned mag;
         longint unsigned norm;
         longint unsigned q;
         int              n;
         norm_result_type res;
         ev  = e;
         mag = (ev < 0) ? -ev : ev;
         vector_q.push_back(e);
         square_sum += mag * mag;
         if (vector_q.size() < effective_dims(dims_reg)) return;
         n    = vector_q.size();
         norm = floor_root(square_sum + 1);
         if (norm == 0) norm = 1;
         for (int k = 0; k < n; k++) begin
            ev  = vector_q[k];
            mag = (ev < 0) ? -ev : ev;
            q   = (mag << FRAC_BITS) / norm;
            if (ev < 0) begin
               res.normalized = (q > Q_ONE) ? OUT_MIN : OUT_BITS'(-longint'(q));
            end else begin
               res.normalized = (q > Q_ONE - 1) ? OUT_MAX : OUT_BITS'(q);
            end
            res.last = (k == n - 1);
            expected_q.push_back(res);
         end
         vector_q.delete();
         square_sum = 0;
      endfunction

      task check_result(logic signed [OUT_BITS-1:0] got_norm, logic got_last);
         norm_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result %0d last %0b", got_norm, got_last));
            return;
         end
         want = expected_q.pop_front();
         if (got_norm !== want.normalized)
            report($sformatf("normalized %0d, want %0d", got_norm, want.normalized));
         if (got_last !== want.last)
            report($sformatf("last %0b, want %0b", got_last, want.last));
      endtask

      task report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [PADDR_BITS-1:0] csr_paddr;
   logic [PDATA_BITS-1:0] csr_pwdata;
   logic [PDATA_BITS-1:0] csr_prdata;
   logic                  csr_pready;

   vln_req_if req_if ();
   vln_rsp_if rsp_if ();

   norm_scoreboard sb = new();

   bit quiet_mode     = 1'b0;   // no idling on either side
   bit hold_requested = 1'b0;   // receiver holds off for a long stretch
   int random_items   = 0;
   int cycle_count    = 0;

   vector_l2_normalizer u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic signed [ELEM_BITS-1:0] rand_element();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return ELEM_BITS'(int'($urandom_range(0, 30)) - 15);
         default: return ELEM_BITS'($urandom());
      endcase
   endfunction

   // handshakes are observed at the falling edge, where everything is settled
   always @(negedge clock) begin
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == DIMS_ADDR)
            sb.set_dims(csr_pwdata[DIMS_BITS-1:0]);
         if (req_if.valid && req_if.ready)
            sb.note_element(req_if.element);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.normalized, rsp_if.last);
      end
   end

   // result receiver: random stalls, quiet stretches, one long hold-off
   initial begin
      int n;
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_requested) begin
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
            hold_requested = 1'b0;
         end else if (quiet_mode) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            n = gap_cycles();
            if (n > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // run limit
   initial begin
      wait (!reset);
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // offer one item; returns at the edge that accepts it
   task send_element(logic signed [ELEM_BITS-1:0] e);
      int n;
      n = quiet_mode ? 0 : gap_cycles();
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.element <= e;
      @(negedge clock);
      while (!req_if.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task send_vector(int len);
      for (int i = 0; i < len; i++) begin
         send_element(rand_element());
         random_items++;
      end
   endtask

   // stop offering, wait for every queued result, then let the block settle
   task drain_results();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write dims (upper data bits random) and read it back
   task write_dims(logic [DIMS_BITS-1:0] d);
      logic [PDATA_BITS-1:0] data;
      data = $urandom();
      data[DIMS_BITS-1:0] = d;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= DIMS_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      if (csr_prdata[DIMS_BITS-1:0] !== d)
         sb.report($sformatf("dims read %0d, want %0d", csr_prdata[DIMS_BITS-1:0], d));
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic [DIMS_BITS-1:0] d;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.element = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // one-element vectors: a full-scale element saturates or hits -1.0
      write_dims(1);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element(0);
      send_element(1);
      send_element(-1);
      send_element(12345);
      drain_results();

      // dims of zero behaves as one
      write_dims(0);
      send_element(-7);
      send_element(300);
      drain_results();

      // pairs: extremes, a 3-4-5 style case, all-zero vector
      write_dims(2);
      send_element(ELEM_MAX);
      send_element(ELEM_MIN);
      send_element(3);
      send_element(4);
      send_element(0);
      send_element(0);
      drain_results();

      // dims lowered mid-vector: the next element closes all three
      write_dims(3);
      send_element(7);
      send_element(-9);
      drain_results();
      write_dims(1);
      send_element(12);
      drain_results();

      // no idling on either side
      quiet_mode = 1'b1;
      d = DIMS_BITS'($urandom_range(2, 8));
      write_dims(d);
      repeat (4) send_vector(sb.effective_dims(d));
      drain_results();
      quiet_mode = 1'b0;

      // receiver holds off while elements keep coming; input backs up
      write_dims(4);
      hold_requested = 1'b1;
      repeat (6) send_vector(4);
      drain_results();

      // register maximum: one full-length vector
      write_dims({DIMS_BITS{1'b1}});
      send_vector(MAX_DIMS);
      drain_results();

      // mostly short vectors with random dims
      while (random_items < RANDOM_ITEMS) begin
         d = ($urandom_range(0, 9) == 0) ? '0 : DIMS_BITS'($urandom_range(1, 8));
         write_dims(d);
         repeat ($urandom_range(2, 5)) send_vector(sb.effective_dims(d));
         drain_results();
      end

      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
